### hdl/assert_macros.svh
// assertion macros for the checker file lbp_checker.sv
// no dependencies; each macro expects clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/lbp_pkg.sv
// shared types and constants for the lbp feature stream
// no dependencies
package lbp_pkg;

	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_DATA_W   = 13;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int ROW_W        = 12;
	localparam int CODE_W       = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [HEIGHT_REG_W-1:0] MIN_SIZE_H   = 13'd3;
	localparam logic [HEIGHT_REG_W-1:0] ROW_LIMIT    = 13'd4096;

	// window control from the top level to the window unit
	typedef struct packed {
		logic shift;
		logic emit;
		logic last;
	} lbp_ctl_t;

endpackage

### hdl/lbp_ram.sv
// generic simple dual-port ram, registered read, old data on read-during-write
// no dependencies
module lbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/lbp_window.sv
// 3x3 window registers and the eight neighbour compares
// depends on lbp_pkg for the control struct and code width
module lbp_window #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lbp_pkg::lbp_ctl_t          ctl,
	input  logic [PIXEL_BITS-1:0]      col_top,
	input  logic [PIXEL_BITS-1:0]      col_mid,
	input  logic [PIXEL_BITS-1:0]      col_bot,
	output logic [lbp_pkg::CODE_W-1:0] code
);

	// win_q[row][col], col 0 is the oldest column
	logic [PIXEL_BITS-1:0] win_q [3][3];
	logic [PIXEL_BITS-1:0] ctr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (ctl.shift) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col_top;
			win_q[1][2] <= col_mid;
			win_q[2][2] <= col_bot;
		end
	end

	// code of the window as it stands after this shift
	assign ctr = win_q[1][2];
	always_comb begin
		code[7] = win_q[0][1] > ctr;
		code[6] = win_q[0][2] > ctr;
		code[5] = col_top > ctr;
		code[4] = col_mid > ctr;
		code[3] = col_bot > ctr;
		code[2] = win_q[2][2] > ctr;
		code[1] = win_q[2][1] > ctr;
		code[0] = win_q[1][1] > ctr;
	end

endmodule

### hdl/lbp_3x3_feature_stream.sv
// lbp_3x3_feature_stream: 3x3 local binary pattern over a raster depth stream
// depends on lbp_pkg, lbp_ram, lbp_window
// two register stages, stage 1 and the output, lie between a bottom-right pixel and its code
// throughput: one pixel per cycle unless the output stalls; the line-buffer read sets the latency
// reset: counters, window and output valid clear at once, sizes return to 640x480
// line buffers get no clearing pass; the stale data that rows 0 and 1 read never reaches a code
module lbp_3x3_feature_stream #(
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_wr_en,
	input  logic [lbp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	// pixel requests
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [PIXEL_BITS-1:0]           depth,
	input  logic                            frame_start,
	// code requests
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lbp_pkg::CODE_W-1:0]      lbp_code,
	output logic                            last_code
);

	localparam int CW  = $clog2(MAX_WIDTH);  // column index bits
	localparam int EWW = CW + 1;             // holds MAX_WIDTH itself

	// configuration registers
	logic [lbp_pkg::WIDTH_REG_W-1:0]  width_q;
	logic [lbp_pkg::HEIGHT_REG_W-1:0] height_q;

	// position counters
	logic [CW-1:0]            col_q;
	logic [lbp_pkg::ROW_W-1:0] row_q;

	// stage 1: pixel waiting for its line-buffer data
	logic                  v_s1;
	logic [PIXEL_BITS-1:0] pix_s1;
	logic [CW-1:0]         col_s1;
	logic                  emit_s1;
	logic                  last_s1;
	logic                  fwd_s1;
	logic [PIXEL_BITS-1:0] fwd_top_s1;
	logic [PIXEL_BITS-1:0] fwd_mid_s1;

	// output register
	logic                       out_valid_q;
	logic [lbp_pkg::CODE_W-1:0] code_q;
	logic                       last_q;

	logic                       accept;
	logic                       adv_s1;
	logic [EWW-1:0]             eff_w;
	logic [lbp_pkg::HEIGHT_REG_W-1:0] eff_h;
	logic [CW-1:0]              col0;
	logic [lbp_pkg::ROW_W-1:0]  row0;
	logic [EWW-1:0]             col0_ext;
	logic [lbp_pkg::HEIGHT_REG_W-1:0] row0_ext;
	logic                       emit0;
	logic                       last0;
	logic [PIXEL_BITS-1:0]      ram_top;
	logic [PIXEL_BITS-1:0]      ram_mid;
	logic [PIXEL_BITS-1:0]      top_eff;
	logic [PIXEL_BITS-1:0]      mid_eff;
	lbp_pkg::lbp_ctl_t          win_ctl;
	logic [lbp_pkg::CODE_W-1:0] win_code;

	// stage 1 moves on when the output register is free or being drained
	assign adv_s1   = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// effective sizes, clamped to the supported range
	always_comb begin
		if (32'(width_q) < 32'd3) begin
			eff_w = EWW'(3);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			eff_w = EWW'(MAX_WIDTH);
		end else begin
			eff_w = EWW'(width_q);
		end
		if (height_q < lbp_pkg::MIN_SIZE_H) begin
			eff_h = lbp_pkg::MIN_SIZE_H;
		end else if (height_q > lbp_pkg::ROW_LIMIT) begin
			eff_h = lbp_pkg::ROW_LIMIT;
		end else begin
			eff_h = height_q;
		end
	end

	// position of the incoming pixel; frame start restarts at the origin
	assign col0     = frame_start ? '0 : col_q;
	assign row0     = frame_start ? '0 : row_q;
	assign col0_ext = EWW'(col0);
	assign row0_ext = lbp_pkg::HEIGHT_REG_W'(row0);
	assign emit0    = (row0 >= lbp_pkg::ROW_W'(2)) && (col0 >= CW'(2));
	assign last0    = (row0_ext == eff_h - lbp_pkg::HEIGHT_REG_W'(1)) &&
	                  (col0_ext == eff_w - EWW'(1));

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= lbp_pkg::WIDTH_RESET;
			height_q <= lbp_pkg::HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				lbp_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_wdata[lbp_pkg::WIDTH_REG_W-1:0];
				end
				lbp_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_wdata[lbp_pkg::HEIGHT_REG_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// raster counters; a counter past a shrunk size wraps on its next step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col0_ext + EWW'(1) < eff_w) begin
				col_q <= col0 + CW'(1);
				row_q <= row0;
			end else begin
				col_q <= '0;
				if (row0_ext + lbp_pkg::HEIGHT_REG_W'(1) < eff_h) begin
					row_q <= row0 + lbp_pkg::ROW_W'(1);
				end else begin
					row_q <= '0;
				end
			end
		end
	end

	// line buffers: read at acceptance, written back when stage 1 moves on
	lbp_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_two_rows_above (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(col_s1),
		.wdata(mid_eff),
		.re   (accept),
		.raddr(col0),
		.rdata(ram_top)
	);

	lbp_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_WIDTH)
	) u_row_above (
		.clk  (clk),
		.we   (adv_s1),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(col0),
		.rdata(ram_mid)
	);

	// the ram returns old data when its column is written in the same cycle
	// (a frame start right after a pixel in column 0); take the values being written instead
	assign top_eff = fwd_s1 ? fwd_top_s1 : ram_top;
	assign mid_eff = fwd_s1 ? fwd_mid_s1 : ram_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= depth;
			col_s1     <= col0;
			emit_s1    <= emit0;
			last_s1    <= last0;
			fwd_s1     <= adv_s1 && (col_s1 == col0);
			fwd_top_s1 <= mid_eff;
			fwd_mid_s1 <= pix_s1;
		end
	end

	// window shift and compares
	always_comb begin
		win_ctl.shift = adv_s1;
		win_ctl.emit  = emit_s1;
		win_ctl.last  = last_s1;
	end

	lbp_window #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (win_ctl),
		.col_top(top_eff),
		.col_mid(mid_eff),
		.col_bot(pix_s1),
		.code   (win_code)
	);

	// output register; border pixels leave no code behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= win_ctl.emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && win_ctl.emit) begin
			code_q <= win_code;
			last_q <= win_ctl.last;
		end
	end

	assign out_valid = out_valid_q;
	assign lbp_code  = code_q;
	assign last_code = last_q;

endmodule

### hdl/lbp_checker.sv
// port-level checks for lbp_3x3_feature_stream, attached by bind
// depends on assert_macros.svh
`include "assert_macros.svh"

module lbp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] lbp_code,
	input logic       last_code
);

	// a stalled code stays offered
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// a stalled code keeps its payload
	`ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(lbp_code) && $stable(last_code))
	// with the output empty the pipeline always takes a pixel
	`ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready)
	// a fresh code comes from a pixel that went straight through stage 1 into the output register
	`ASSERT_SAME(a_rise_latency, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind lbp_3x3_feature_stream lbp_checker u_lbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.lbp_code (lbp_code),
	.last_code(last_code)
);

### test/lbp_3x3_feature_stream_tb.sv
// testbench for lbp_3x3_feature_stream: random and directed depth frames, codes checked
// against an in-bench window predictor with typed-in values for two directed frames
// depends on lbp_pkg and the lbp_3x3_feature_stream rtl
module lbp_3x3_feature_stream_tb;

	localparam int MAX_W    = 1024;
	localparam int PIX_W    = 16;
	localparam int MIN_DIM  = 3;
	localparam int LAT_IDLE = 4;     // cycles to let in-flight pixels settle
	localparam int WD_LIMIT = 1000;  // cycles with no request moved on either side
	localparam int DIR_ROWS = 29;

	typedef struct packed {
		logic [lbp_pkg::CODE_W-1:0] code;
		logic                       last;
	} code_rec_t;

	// one row of the directed frames; typed rows carry their own expected code
	typedef struct {
		logic [PIX_W-1:0]           d;
		logic                       fs;
		bit                         typed;
		logic [lbp_pkg::CODE_W-1:0] code;
		logic                       last;
	} dir_row_t;

	localparam code_rec_t NO_CODE = '0;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_wr_en   = 1'b0;
	logic [lbp_pkg::CFG_INDEX_W-1:0] cfg_index   = lbp_pkg::REG_IMAGE_WIDTH;
	logic [lbp_pkg::CFG_DATA_W-1:0]  cfg_wdata   = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_ready;
	logic [PIX_W-1:0]                depth       = '0;
	logic                            frame_start = 1'b0;
	logic                            out_valid;
	logic                            out_ready   = 1'b0;
	logic [lbp_pkg::CODE_W-1:0]      lbp_code;
	logic                            last_code;

	lbp_3x3_feature_stream #(
		.MAX_WIDTH (MAX_W),
		.PIXEL_BITS(PIX_W)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.depth      (depth),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.lbp_code   (lbp_code),
		.last_code  (last_code)
	);

	always #1 clk = ~clk;

	// predictor state: sizes, two line buffers, 3x3 window, raster position
	bit [lbp_pkg::WIDTH_REG_W-1:0]  width_reg  = lbp_pkg::WIDTH_RESET;
	bit [lbp_pkg::HEIGHT_REG_W-1:0] height_reg = lbp_pkg::HEIGHT_RESET;
	bit [PIX_W-1:0]        row1_mem [MAX_W];
	bit [PIX_W-1:0]        row2_mem [MAX_W];
	bit [PIX_W-1:0]        win [3][3];
	int                    col_pos = 0;
	int                    row_pos = 0;

	code_rec_t code_q[$];   // codes still owed by the block, oldest first
	int        mismatch_cnt = 0;
	int        burst_left   = 0;
	int        idle_cnt     = 0;
	int        rx_tick      = 0;
	int        rx_mode      = 0;
	dir_row_t  dir_tab [DIR_ROWS];

	task automatic report_mismatch(input string what);
		// keep the log short when the block is badly off
		if (mismatch_cnt < 100)
			$display("mismatch at %0t: %s", $time, what);
		mismatch_cnt++;
	endtask

	// add one owed code at the tail of the queue
	task automatic owe_code(input code_rec_t rec);
		code_q = {code_q, rec};
	endtask

	// advance the window by one accepted pixel; returns 1 when a code falls out
	function automatic bit lbp_window_step(input logic [PIX_W-1:0] pix, input logic fs,
			output code_rec_t res);
		int               w;
		int               h;
		int               c;
		int               r;
		int               k;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] ctr;
		w = width_reg;
		h = height_reg;
		// out-of-range sizes clamp to the smallest and largest usable frame
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_W) w = MAX_W;
		if (h < MIN_DIM) h = MIN_DIM;
		if (h > lbp_pkg::ROW_LIMIT) h = lbp_pkg::ROW_LIMIT;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		c = col_pos;
		r = row_pos;
		top = row2_mem[c];
		mid = row1_mem[c];
		row2_mem[c] = mid;
		row1_mem[c] = pix;
		for (k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = pix;
		// strict greater-than, top-left clockwise down to left
		ctr = win[1][1];
		res.code = {win[0][0] > ctr, win[0][1] > ctr, win[0][2] > ctr, win[1][2] > ctr,
			win[2][2] > ctr, win[2][1] > ctr, win[2][0] > ctr, win[1][0] > ctr};
		res.last = (r == h - 1) && (c == w - 1);
		// a counter left beyond a shrunk size wraps on this advance
		if (c + 1 < w) begin
			col_pos = c + 1;
		end else begin
			col_pos = 0;
			row_pos = (r + 1 < h) ? r + 1 : 0;
		end
		return (r >= 2) && (c >= 2);
	endfunction

	// mostly full-range depth, with plenty of ties and rail values
	function automatic logic [PIX_W-1:0] pick_depth();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3:    return PIX_W'($urandom_range(0, 3));
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// one pixel request; the sender runs in bursts with random gaps in between
	task automatic send_pixel(input logic [PIX_W-1:0] d, input logic fs, input bit typed,
			input code_rec_t typed_res);
		int        gap;
		code_rec_t res;
		bit        hit;
		if (burst_left == 0) begin
			// now and then a long burst gives a stretch with no sender gaps
			burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		burst_left--;
		in_valid    <= 1'b1;
		depth       <= d;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		// accepted at this edge
		hit = lbp_window_step(d, fs, res);
		if (typed)
			owe_code(typed_res);
		else if (hit)
			owe_code(res);
	endtask

	// hold the sender until every owed code has come back
	task automatic drain_codes();
		in_valid <= 1'b0;
		do @(posedge clk); while (code_q.size() != 0);
	endtask

	// sizes are only written with the block idle, so drain and let the pipe empty first
	task automatic set_size(input logic [lbp_pkg::CFG_DATA_W-1:0] w_wr,
			input logic [lbp_pkg::CFG_DATA_W-1:0] h_wr);
		drain_codes();
		repeat (LAT_IDLE) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= lbp_pkg::REG_IMAGE_WIDTH;
		cfg_wdata <= w_wr;
		@(posedge clk);
		width_reg = w_wr[lbp_pkg::WIDTH_REG_W-1:0];
		cfg_index <= lbp_pkg::REG_IMAGE_HEIGHT;
		cfg_wdata <= h_wr;
		@(posedge clk);
		height_reg = h_wr[lbp_pkg::HEIGHT_REG_W-1:0];
		cfg_wr_en <= 1'b0;
	endtask

	// random frames; restart=0 carries on the frame left by the last phase
	task automatic run_phase(input logic [lbp_pkg::CFG_DATA_W-1:0] w_wr,
			input logic [lbp_pkg::CFG_DATA_W-1:0] h_wr,
			input bit do_cfg, input bit restart, input int n_pix);
		int   i;
		logic fs;
		if (do_cfg)
			set_size(w_wr, h_wr);
		for (i = 0; i < n_pix; i++) begin
			// frame marker mostly on frame heads, sometimes dropped (wrap), rarely mid-frame
			if (i == 0)
				fs = restart;
			else if (col_pos == 0 && row_pos == 0)
				fs = ($urandom_range(0, 3) != 0);
			else
				fs = ($urandom_range(0, 59) == 0);
			send_pixel(pick_depth(), fs, 1'b0, NO_CODE);
			if ($urandom_range(0, 249) == 0)
				drain_codes();
		end
	endtask

	// receiver: ready pattern redrawn when tick bits 5:0 are zero, among free-running,
	// coin toss, a stall when tick bits 2:0 read five, and long stalls following tick bit 3
	always @(posedge clk) begin
		rx_tick <= rx_tick + 1;
		if (rx_tick[5:0] == 6'd0)
			rx_mode <= $urandom_range(0, 3);
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= 1'($urandom_range(0, 1));
			2:       out_ready <= (rx_tick[2:0] != 3'd5);
			default: out_ready <= rx_tick[3];
		endcase
	end

	// code checker, oldest expectation first
	always @(posedge clk) begin
		code_rec_t want;
		if (arst_n && out_valid && out_ready) begin
			if (code_q.size() == 0) begin
				report_mismatch($sformatf("code %02h with no pixel owing one", lbp_code));
			end else begin
				want = code_q.pop_front();
				if (lbp_code !== want.code)
					report_mismatch($sformatf("lbp_code got %02h want %02h", lbp_code, want.code));
				if (last_code !== want.last)
					report_mismatch($sformatf("last_code got %b want %b", last_code, want.last));
			end
		end
	end

	// watchdog on cycles where no request moves on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt == WD_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int i;
		// 3x3 frames: rail values around a zero centre, a wrapped frame with ties
		// giving alternating bits, two stray pixels, then a mid-frame restart
		dir_tab = '{
			'{16'hFFFF, 1'b1, 1'b0, 8'h00, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
			'{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
			'{16'h0000, 1'b0, 1'b0, 8'h00, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
			'{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
			'{16'hFFFF, 1'b0, 1'b1, 8'hFF, 1'b1},
			'{16'd99,   1'b0, 1'b0, 8'h00, 1'b0}, '{16'd101,  1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd100,  1'b0, 1'b0, 8'h00, 1'b0}, '{16'd101,  1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd100,  1'b0, 1'b0, 8'h00, 1'b0}, '{16'd101,  1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd100,  1'b0, 1'b0, 8'h00, 1'b0}, '{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0},
			'{16'h0000, 1'b0, 1'b1, 8'h55, 1'b1},
			'{16'h0001, 1'b0, 1'b0, 8'h00, 1'b0}, '{16'h8000, 1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd7,    1'b1, 1'b0, 8'h00, 1'b0}, '{16'd0,    1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd300,  1'b0, 1'b0, 8'h00, 1'b0}, '{16'd8,    1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd8,    1'b0, 1'b0, 8'h00, 1'b0}, '{16'd9,    1'b0, 1'b0, 8'h00, 1'b0},
			'{16'hFFFF, 1'b0, 1'b0, 8'h00, 1'b0}, '{16'd8,    1'b0, 1'b0, 8'h00, 1'b0},
			'{16'd1,    1'b0, 1'b0, 8'h00, 1'b0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 640x480: too short for a code, so nothing may come out
		run_phase('0, '0, 1'b0, 1'b1, 20);

		// directed frames at the smallest size
		set_size(13'd3, 13'd3);
		for (i = 0; i < DIR_ROWS; i++)
			send_pixel(dir_tab[i].d, dir_tab[i].fs, dir_tab[i].typed,
				'{dir_tab[i].code, dir_tab[i].last});

		// zero and one clamp up to 3x3
		run_phase(13'd0, 13'd1, 1'b1, 1'b1, 90);
		run_phase(13'd5, 13'd4, 1'b1, 1'b1, 160);
		// all-ones writes: width clamps to the line buffer, height to the row limit
		run_phase(13'h1FFF, 13'h1FFF, 1'b1, 1'b1, 150);
		// shrink width mid-row, column beyond it wraps; upper data bits ignored for width
		run_phase(13'h1804, 13'h1FFF, 1'b1, 1'b0, 120);
		// shrink height with the row counter far beyond it
		run_phase(13'd4, 13'd3, 1'b1, 1'b0, 120);
		run_phase(13'd2, 13'h1000, 1'b1, 1'b1, 60);
		run_phase(13'd9, 13'd0, 1'b1, 1'b1, 160);
		repeat (3)
			run_phase(13'($urandom_range(3, 12)), 13'($urandom_range(3, 8)), 1'b1, 1'b1, 60);

		drain_codes();
		repeat (LAT_IDLE * 2) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
